// File: rtl/core/utl_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 line transcoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package utl_pkg;

	// Edit kinds carried on the output tuser.
	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	// Control code units.
	localparam logic [15:0] CU_BACKSPACE = 16'd8;
	localparam logic [15:0] CU_ENTER     = 16'd13;

	// Upper six bits of the two surrogate ranges.
	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

	// Command queue depth between front and back (power of two).
	localparam int unsigned QUEUE_DEPTH = 4;

	// One queued command: the edit kind, up to four bytes (first byte in
	// the lowest lane) and the index of the final byte.
	typedef struct packed {
		action_t         action;
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
	} utl_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/utl_front.sv
// Front end: accepts code units, tracks the pending surrogate and the line
// length, and turns each code unit into at most one queued command. Uses utl_pkg.
`default_nettype none

module utl_front #(
	parameter int unsigned LINE_LIMIT = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [15:0]      code_unit,
	input  wire logic             q_full,
	output logic                  q_push,
	output utl_pkg::utl_cmd_t     q_cmd
);
	import utl_pkg::*;

	localparam int unsigned LEN_W = $clog2(LINE_LIMIT + 5);
	localparam logic [LEN_W-1:0] LIMIT_L = LEN_W'(LINE_LIMIT);

	logic             pend_valid_q;
	logic [9:0]       pend_bits_q;
	logic [LEN_W-1:0] line_len_q;

	logic        accept;
	logic        is_bs;
	logic        is_enter;
	logic        is_high;
	logic        is_low;
	logic        is_char;
	logic        room;
	logic [20:0] cp;
	logic [1:0]  enc_last;
	logic [3:0][7:0] enc_bytes;

	// The queue is the only thing that stalls the input.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the incoming code unit.
	assign is_bs    = (code_unit == CU_BACKSPACE);
	assign is_enter = (code_unit == CU_ENTER);
	assign is_high  = (code_unit[15:10] == SURR_HIGH_TAG);
	assign is_low   = (code_unit[15:10] == SURR_LOW_TAG);
	assign is_char  = !is_bs && !is_enter && !is_high && !(is_low && !pend_valid_q);
	assign room     = !(line_len_q > LIMIT_L);

	// Form the code point; a low surrogate here always has a partner.
	always_comb begin
		if (is_low) begin
			cp = 21'h10000 + {1'b0, pend_bits_q, code_unit[9:0]};
		end else begin
			cp = {5'd0, code_unit};
		end
	end

	// UTF-8 encoding of the code point.
	always_comb begin
		enc_bytes = '0;
		if (cp < 21'h80) begin
			enc_last     = 2'd0;
			enc_bytes[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			enc_last     = 2'd1;
			enc_bytes[0] = {3'b110, cp[10:6]};
			enc_bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			enc_last     = 2'd2;
			enc_bytes[0] = {4'b1110, cp[15:12]};
			enc_bytes[1] = {2'b10, cp[11:6]};
			enc_bytes[2] = {2'b10, cp[5:0]};
		end else begin
			enc_last     = 2'd3;
			enc_bytes[0] = {5'b11110, cp[20:18]};
			enc_bytes[1] = {2'b10, cp[17:12]};
			enc_bytes[2] = {2'b10, cp[11:6]};
			enc_bytes[3] = {2'b10, cp[5:0]};
		end
	end

	// Command toward the queue.
	always_comb begin
		q_push       = 1'b0;
		q_cmd.action = ACT_APPEND;
		q_cmd.last_idx = 2'd0;
		q_cmd.bytes  = '0;
		if (is_bs) begin
			q_push       = accept && (line_len_q != '0);
			q_cmd.action = ACT_DELETE;
		end else if (is_enter) begin
			q_push       = accept;
			q_cmd.action = ACT_CLEAR;
		end else if (is_char) begin
			q_push         = accept && room;
			q_cmd.last_idx = enc_last;
			q_cmd.bytes    = enc_bytes;
		end
	end

	// Surrogate and line-length state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_bits_q  <= '0;
			line_len_q   <= '0;
		end else if (accept) begin
			if (is_high) begin
				pend_valid_q <= 1'b1;
				pend_bits_q  <= code_unit[9:0];
			end else if (!(is_low && !pend_valid_q)) begin
				pend_valid_q <= 1'b0;
			end
			if (is_bs) begin
				if (line_len_q != '0) begin
					line_len_q <= line_len_q - LEN_W'(1);
				end
			end else if (is_enter) begin
				line_len_q <= '0;
			end else if (is_char && room) begin
				line_len_q <= line_len_q + LEN_W'({1'b0, enc_last}) + LEN_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/utl_queue.sv
// Small command queue that decouples the front end from the byte emitter.
// Uses utl_pkg for the command type and the depth.
`default_nettype none

module utl_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire utl_pkg::utl_cmd_t push_cmd,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output utl_pkg::utl_cmd_t     head_cmd
);
	import utl_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	utl_cmd_t         slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slots_q[rd_ptr_q];

	// Storage slots; no reset needed on the payload.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/utl_back.sv
// Back end: takes commands from the queue and emits one result per cycle,
// while the output is not stalled, into a registered output stage. Uses utl_pkg.
`default_nettype none

module utl_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire utl_pkg::utl_cmd_t q_cmd,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            out_action,
	output logic [7:0]            out_byte,
	output logic                  out_last
);
	import utl_pkg::*;

	logic       cur_valid_q;
	utl_cmd_t   cur_q;
	logic [1:0] idx_q;
	logic       emit;
	logic       cur_done;

	// A result moves into the output register whenever that register is free
	// or being drained this cycle.
	assign emit     = cur_valid_q && (!out_valid || out_ready);
	assign cur_done = emit && (idx_q == cur_q.last_idx);
	assign q_pop    = q_valid && (!cur_valid_q || cur_done);

	// Current command and byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_action <= cur_q.action;
			out_byte   <= cur_q.bytes[idx_q];
			out_last   <= (idx_q == cur_q.last_idx);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/utf16_to_utf8_line_transcoder.sv
// UTF-16 to UTF-8 line transcoder, top level.
// Input stream s_axis carries one UTF-16 code unit per transaction in tdata.
// Output stream m_axis carries one line edit per transaction: tuser holds the
// kind (append byte, delete last byte, clear line), tdata the byte to append
// (zero for delete and clear), and tlast marks the final edit of a code unit.
// A code unit causes zero to four output transactions; high surrogates,
// orphan low surrogates, backspace on an empty line and characters past the
// line limit cause none.
// Timing: the first edit of a code unit passes the queue slot, the current
// command register and the output register before it is on m_axis.
// Throughput: one output transaction per cycle while m_axis_tready is high;
// input is taken every cycle while the four-entry command queue has room.
// Reset clears the pending surrogate, the line length, the queue and the
// output register. When m_axis stalls, the output register holds its
// transaction, the queue fills, and s_axis tready drops once it is full.
// Depends on utl_pkg, utl_front, utl_queue and utl_back.
`default_nettype none

module utf16_to_utf8_line_transcoder #(
	parameter int unsigned LINE_LIMIT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]       m_axis_tuser,   // [1:0] action
	output logic             m_axis_tlast    // last
);
	import utl_pkg::*;

	logic     push;
	logic     full;
	logic     pop;
	logic     head_valid;
	utl_cmd_t push_cmd;
	utl_cmd_t head_cmd;

	utl_front #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.code_unit(s_axis_tdata),
		.q_full   (full),
		.q_push   (push),
		.q_cmd    (push_cmd)
	);

	utl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	utl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (head_valid),
		.q_cmd     (head_cmd),
		.q_pop     (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_action(m_axis_tuser),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: bench/utf16_to_utf8_line_transcoder_test.sv
// Self-checking bench for the UTF-16 to UTF-8 line transcoder.
// Covers a directed table of corner units and then random code-unit traffic
// under four idling phases. Depends on utl_pkg and utf16_to_utf8_line_transcoder.
`timescale 1ns / 1ps

module utf16_to_utf8_line_transcoder_test;
	import utl_pkg::*;

	localparam int unsigned LINE_LIMIT  = 64;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_UNITS = 40;

	// One line edit as seen on the output stream.
	typedef struct packed {
		action_t    action;
		logic [7:0] data;
		logic       last;
	} edit_t;

	// One row of directed stimulus. Where typed is set, the expected edits are
	// given here: count edits of one kind, bytes first byte in the lowest lane.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        typed;
		logic [2:0]  count;
		action_t     action;
		logic [31:0] bytes;
	} stim_row_t;

	localparam int unsigned DIRECTED_ROWS = 24;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{16'h0008, 1'b1, 3'd0, ACT_APPEND, 32'h0000_0000},  // backspace, empty line
		'{16'h000D, 1'b1, 3'd1, ACT_CLEAR,  32'h0000_0000},  // enter, empty line
		'{16'h0000, 1'b1, 3'd1, ACT_APPEND, 32'h0000_0000},  // code unit zero
		'{16'h007F, 1'b1, 3'd1, ACT_APPEND, 32'h0000_007F},
		'{16'h0080, 1'b1, 3'd2, ACT_APPEND, 32'h0000_80C2},
		'{16'h07FF, 1'b1, 3'd2, ACT_APPEND, 32'h0000_BFDF},
		'{16'h0800, 1'b1, 3'd3, ACT_APPEND, 32'h0080_A0E0},
		'{16'hFFFF, 1'b1, 3'd3, ACT_APPEND, 32'h00BF_BFEF},
		'{16'h0008, 1'b1, 3'd1, ACT_DELETE, 32'h0000_0000},
		'{16'hD800, 1'b1, 3'd0, ACT_APPEND, 32'h0000_0000},
		'{16'hDC00, 1'b1, 3'd4, ACT_APPEND, 32'h8080_90F0},  // U+10000
		'{16'hDBFF, 1'b1, 3'd0, ACT_APPEND, 32'h0000_0000},
		'{16'hDFFF, 1'b1, 3'd4, ACT_APPEND, 32'hBFBF_8FF4},  // U+10FFFF
		'{16'hDC00, 1'b1, 3'd0, ACT_APPEND, 32'h0000_0000},  // orphan low surrogate
		'{16'hD800, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},
		'{16'hDBFF, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},  // replaces held high
		'{16'hDC00, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},
		'{16'hD800, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},
		'{16'h0041, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},  // plain unit drops held high
		'{16'hD800, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},
		'{16'h0008, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},  // backspace drops held high
		'{16'hDC00, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},
		'{16'hD800, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000},
		'{16'h000D, 1'b0, 3'd0, ACT_APPEND, 32'h0000_0000}   // enter drops held high
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'h0000;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Shadow state of the transcoder.
	logic [15:0] held_high = 16'h0000;
	int unsigned line_bytes = 0;

	edit_t       edits_due [$];
	logic [15:0] unit_batch [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int units_sent = 0;
	int appends_seen = 0;
	int deletes_seen = 0;
	int clears_seen = 0;

	utf16_to_utf8_line_transcoder #(
		.LINE_LIMIT(LINE_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #10 clk = ~clk;

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Works out the line edits caused by one code unit and advances the
	// shadow surrogate and line length.
	function automatic int transcode_unit(input logic [15:0] cu, output edit_t edits [4]);
		logic [20:0] cp;
		logic [7:0]  b [4];
		int          n;
		n = 0;
		for (int i = 0; i < 4; i++) begin
			edits[i] = '{ACT_APPEND, 8'h00, 1'b0};
			b[i] = 8'h00;
		end
		if (cu == CU_BACKSPACE) begin
			held_high = 16'h0000;
			if (line_bytes == 0)
				return 0;
			line_bytes--;
			edits[0] = '{ACT_DELETE, 8'h00, 1'b1};
			return 1;
		end
		if (cu == CU_ENTER) begin
			held_high = 16'h0000;
			line_bytes = 0;
			edits[0] = '{ACT_CLEAR, 8'h00, 1'b1};
			return 1;
		end
		if (cu[15:10] == SURR_HIGH_TAG) begin
			held_high = cu;
			return 0;
		end
		if (cu[15:10] == SURR_LOW_TAG) begin
			if (held_high == 16'h0000)
				return 0;
			cp = 21'h10000 + {1'b0, held_high[9:0], cu[9:0]};
		end else begin
			cp = {5'd0, cu};
		end
		held_high = 16'h0000;

		// The code point is consumed even when the line is already too long.
		if (line_bytes > LINE_LIMIT)
			return 0;

		if (cp < 21'h80) begin
			b[0] = cp[7:0];
			n = 1;
		end else if (cp < 21'h800) begin
			b[0] = {3'b110, cp[10:6]};
			b[1] = {2'b10, cp[5:0]};
			n = 2;
		end else if (cp < 21'h10000) begin
			b[0] = {4'b1110, cp[15:12]};
			b[1] = {2'b10, cp[11:6]};
			b[2] = {2'b10, cp[5:0]};
			n = 3;
		end else begin
			b[0] = {5'b11110, cp[20:18]};
			b[1] = {2'b10, cp[17:12]};
			b[2] = {2'b10, cp[11:6]};
			b[3] = {2'b10, cp[5:0]};
			n = 4;
		end
		for (int i = 0; i < n; i++)
			edits[i] = '{ACT_APPEND, b[i], (i == n - 1)};
		line_bytes += n;
		return n;
	endfunction

	// Offers one code unit, waits for the transaction and queues its edits.
	task automatic put_unit(input stim_row_t row);
		edit_t edits [4];
		int    n;
		@(negedge clk);
		while (roll(send_idle_pct)) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = row.code_unit;
		do
			@(posedge clk);
		while (!s_axis_tready);
		n = transcode_unit(row.code_unit, edits);
		if (row.typed) begin
			for (int i = 0; i < row.count; i++)
				edits_due.push_back('{row.action, row.bytes[8*i +: 8], (i == row.count - 1)});
		end else begin
			for (int i = 0; i < n; i++)
				edits_due.push_back(edits[i]);
		end
		units_sent++;
	endtask

	task automatic put_batch();
		while (unit_batch.size() != 0)
			put_unit('{unit_batch.pop_front(), 1'b0, 3'd0, ACT_APPEND, 32'h0});
	endtask

	// Sender holds off until every queued edit has come out.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (edits_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Queues one short sequence: mostly well-formed text, some noise and
	// broken surrogate sequences.
	task automatic make_sequence();
		logic [31:0] r;
		int          pick;
		r = $urandom();
		pick = $urandom_range(99);
		if (pick < 35) begin
			unit_batch.push_back({SURR_HIGH_TAG, r[9:0]});
			unit_batch.push_back({SURR_LOW_TAG, r[19:10]});
		end else if (pick < 65) begin
			case ($urandom_range(2))
				0: unit_batch.push_back(16'($urandom_range(16'h007F)));
				1: unit_batch.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
				default: begin
					if (r[31])
						unit_batch.push_back(16'($urandom_range(16'hD7FF, 16'h0800)));
					else
						unit_batch.push_back(16'($urandom_range(16'hFFFF, 16'hE000)));
				end
			endcase
		end else if (pick < 80) begin
			unit_batch.push_back(r[15:0]);
		end else if (pick < 88) begin
			unit_batch.push_back(CU_BACKSPACE);
		end else if (pick < 92) begin
			unit_batch.push_back(CU_ENTER);
		end else if (pick < 96) begin
			unit_batch.push_back({SURR_HIGH_TAG, r[9:0]});
			unit_batch.push_back(16'($urandom_range(16'h007F)));
		end else begin
			unit_batch.push_back({SURR_LOW_TAG, r[9:0]});
		end
	endtask

	// Fills the line to exactly the limit with four-byte characters, appends
	// one more, then tries units that must be refused past the limit.
	task automatic make_line_fill();
		logic [31:0] r;
		unit_batch.push_back(CU_ENTER);
		for (int i = 0; i < LINE_LIMIT / 4 + 1; i++) begin
			r = $urandom();
			unit_batch.push_back({SURR_HIGH_TAG, r[9:0]});
			unit_batch.push_back({SURR_LOW_TAG, r[19:10]});
		end
		unit_batch.push_back(16'h0041);
		unit_batch.push_back(CU_BACKSPACE);
		unit_batch.push_back(16'h07FF);
		unit_batch.push_back(CU_BACKSPACE);
		unit_batch.push_back(CU_BACKSPACE);
		unit_batch.push_back(16'h0042);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input bit with_fill);
		int start;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (with_fill) begin
			make_line_fill();
			put_batch();
		end
		start = units_sent;
		while (units_sent - start < PHASE_UNITS) begin
			make_sequence();
			put_batch();
		end
		drain();
	endtask

	// Receiver stalls at random at the falling edge.
	always @(negedge clk)
		m_axis_tready <= !roll(recv_stall_pct);

	// Each output transaction is checked against the oldest expected edit.
	always @(posedge clk) begin : check_edits
		edit_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (edits_due.size() == 0) begin
				$error("unexpected edit: action %0d, byte %02h, last %0b",
					m_axis_tuser, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = edits_due.pop_front();
				if (m_axis_tuser !== want.action) begin
					$error("action: expected %0d, actual %0d", want.action, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata !== want.data) begin
					$error("out_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
					errors++;
				end
				case (want.action)
					ACT_DELETE: deletes_seen++;
					ACT_CLEAR:  clears_seen++;
					default:    appends_seen++;
				endcase
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, no idling.
		for (int i = 0; i < DIRECTED_ROWS; i++)
			put_unit(DIRECTED[i]);
		drain();

		run_phase(0, 0, 1'b1);
		run_phase(67, 0, 1'b0);
		run_phase(0, 67, 1'b1);
		run_phase(20, 20, 1'b0);

		$display("Sent %0d code units over four idling phases, with line-limit fills.",
			units_sent);
		$display("Checked %0d appends, %0d deletes and %0d clears.",
			appends_seen, deletes_seen, clears_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
